// ===== rtl/core/lpl_pkg.sv =====
// shared constants, types and table functions of the lookahead peak limiter
package lpl_pkg;

  localparam int MAX_LOOKAHEAD = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int LA_AW = $clog2(MAX_LOOKAHEAD);
  localparam int LEN_W = 9;
  localparam int CFG_W = 16;

  localparam logic signed [16:0] GAIN_FLOOR = -17'sd61440;
  localparam logic signed [16:0] SILENCE_DB = -17'sd30720;
  localparam logic [31:0] LOG2_TO_DB_Q16 = 32'd394566;
  localparam logic [31:0] DB_TO_LOG2_Q16 = 32'd2786635;

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_CEILING,
    REG_RELEASE,
    REG_LOOKAHEAD
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CL_LIN,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LEVEL,
    ST_TARGET,
    ST_REL_A,
    ST_REL_B,
    ST_GAIN_LIN,
    ST_EXP,
    ST_EXP_END,
    ST_PRODUCT,
    ST_OUTPUT
  } state_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = x;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^(b-16)) in Q30
  function automatic logic [30:0] exp_root(input int b);
    logic [63:0] root;
    root = 64'd1 << 29;
    for (int i = 15; i >= b; i--) begin
      root = isqrt64(root << 30);
    end
    return root[30:0];
  endfunction

  localparam logic [30:0] EXP_ROOT [16] = '{
    exp_root(0), exp_root(1), exp_root(2), exp_root(3),
    exp_root(4), exp_root(5), exp_root(6), exp_root(7),
    exp_root(8), exp_root(9), exp_root(10), exp_root(11),
    exp_root(12), exp_root(13), exp_root(14), exp_root(15)
  };

endpackage

// ===== rtl/core/lpl_ram.sv =====
// generic single-port-write ram with registered read
module lpl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lookahead_peak_limiter.sv =====
// lookahead peak limiter top level: level detection, gain smoothing, delay and gain stage
// one transaction at a time; the next input is taken once the result is registered
// (zero input skips the log unit, release adds the states ST_REL_A and ST_REL_B, and the
// first transaction after reset or a ceiling write first recomputes the clip level)
// rate set by the single shared 32x32 multiplier: 16 log squarings and 16 exp steps
// rst clears control state, not the delay ram; delayed samples read as zero until it wraps
module lookahead_peak_limiter
  import lpl_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          clipped,
  output logic signed [16:0]            gain_db,
  output logic [SAMPLE_BITS-1:0]        peak_mag
);

  state_t state, state_next;

  logic signed [15:0] threshold_db;
  logic signed [15:0] ceiling_db;
  logic [15:0] release_coeff;
  logic [LEN_W-1:0] lookahead_len;

  logic signed [16:0] gain_reg;
  logic [SAMPLE_BITS-1:0] peak_reg;
  logic [LA_AW-1:0] dindex;
  logic wrapped;
  logic cl_dirty;
  logic [SAMPLE_BITS-1:0] cl_level;

  logic [SAMPLE_BITS-1:0] mag;
  logic use_delay;
  logic was_wrapped;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] dly;
  logic [4:0] e_pos;
  logic [30:0] m_work;
  logic [15:0] frac;
  logic [3:0] step;
  logic signed [16:0] lvl;
  logic [15:0] target_mag;
  logic [32:0] acc;
  logic [22:0] lreg;
  logic exp_ceil;
  logic [30:0] glin;
  logic [SAMPLE_BITS-1:0] res_mag;
  logic res_clip;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic accept;
  logic [LEN_W-1:0] len_eff;
  logic [LA_AW-1:0] idx_eff;
  logic [LEN_W-1:0] idx_inc;
  logic [SAMPLE_BITS-1:0] mag_in;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic out_free;

  logic [4:0] msb_pos;
  logic [20:0] neg;
  logic [16:0] ceil_n;
  logic [15:0] gain_n;
  logic signed [18:0] lvl_x, thr_x, ceil_x, diff, over, tsum;
  logic signed [16:0] target;
  logic [31:0] sq;
  logic [6:0] ip;
  logic [30:0] exp_val;
  logic [32:0] rel_sum;
  logic [24:0] prod;
  logic [SAMPLE_BITS-1:0] dmag;

  assign accept = sample_valid && sample_ready;
  assign sample_ready = (state == ST_IDLE);
  assign out_free = !result_valid || result_ready;
  assign mag_in = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

  assign len_eff = (lookahead_len > LEN_W'(MAX_LOOKAHEAD)) ? LEN_W'(MAX_LOOKAHEAD)
                                                           : lookahead_len;
  assign idx_eff = ({1'b0, dindex} < len_eff) ? dindex : '0;
  assign idx_inc = LEN_W'(idx_eff) + LEN_W'(1);

  lpl_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_LOOKAHEAD)
  ) u_delay (
    .clk   (clk),
    .we    (accept && (len_eff != '0)),
    .waddr (idx_eff),
    .wdata (sample),
    .re    (accept),
    .raddr (idx_eff),
    .rdata (ram_rdata)
  );

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (mag[i]) begin
        msb_pos = 5'(i);
      end
    end
  end

  assign neg = {5'(SAMPLE_BITS - 1) - e_pos, 16'b0} - {5'b0, frac};
  assign ceil_n = 17'd0 - {ceiling_db[15], ceiling_db};
  assign gain_n = 16'(17'd0 - gain_reg);

  assign lvl_x = 19'(lvl);
  assign thr_x = 19'(threshold_db);
  assign ceil_x = 19'(ceiling_db);
  assign diff = lvl_x - thr_x;
  assign over = lvl_x - ceil_x;
  assign tsum = diff + ((over > 0) ? over : 19'sd0);

  always_comb begin
    if (lvl_x > thr_x) begin
      target = (tsum > 19'sd61440) ? GAIN_FLOOR : 17'(-tsum);
    end else begin
      target = '0;
    end
  end

  assign dmag = dly[SAMPLE_BITS-1] ? SAMPLE_BITS'(-dly) : SAMPLE_BITS'(dly);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_CL_LIN: begin
        mul_a = 32'(ceil_n);
        mul_b = DB_TO_LOG2_Q16;
      end
      ST_GAIN_LIN: begin
        mul_a = 32'(gain_n);
        mul_b = DB_TO_LOG2_Q16;
      end
      ST_LOG_SQ: begin
        mul_a = 32'(m_work);
        mul_b = 32'(m_work);
      end
      ST_LEVEL: begin
        mul_a = 32'(neg);
        mul_b = LOG2_TO_DB_Q16;
      end
      ST_REL_A: begin
        mul_a = 32'(release_coeff);
        mul_b = 32'(gain_n);
      end
      ST_REL_B: begin
        mul_a = 32'(17'h10000 - {1'b0, release_coeff});
        mul_b = 32'(target_mag);
      end
      ST_EXP: begin
        mul_a = 32'(m_work);
        mul_b = 32'(EXP_ROOT[step]);
      end
      ST_PRODUCT: begin
        mul_a = 32'(dmag);
        mul_b = 32'(glin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign sq = mul_p[61:30];
  assign ip = lreg[22:16];
  assign exp_val = (ip >= 7'd31) ? '0 : (m_work >> ip);
  assign rel_sum = acc + mul_p[32:0];
  assign prod = 25'((mul_p[54:0] + 55'(64'd1 << 29)) >> 30);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = cl_dirty ? ST_CL_LIN : ST_LOG_NORM;
        end
      end
      ST_CL_LIN: begin
        state_next = ceiling_db[15] ? ST_EXP : ST_LOG_NORM;
      end
      ST_LOG_NORM: begin
        state_next = (mag == '0) ? ST_TARGET : ST_LOG_SQ;
      end
      ST_LOG_SQ: begin
        if (step == '0) begin
          state_next = ST_LEVEL;
        end
      end
      ST_LEVEL: state_next = ST_TARGET;
      ST_TARGET: state_next = (target < gain_reg) ? ST_GAIN_LIN : ST_REL_A;
      ST_REL_A: state_next = ST_REL_B;
      ST_REL_B: state_next = ST_GAIN_LIN;
      ST_GAIN_LIN: state_next = ST_EXP;
      ST_EXP: begin
        if (step == '0) begin
          state_next = ST_EXP_END;
        end
      end
      ST_EXP_END: state_next = exp_ceil ? ST_LOG_NORM : ST_PRODUCT;
      ST_PRODUCT: state_next = ST_OUTPUT;
      ST_OUTPUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db <= -16'sd256;
      ceiling_db <= -16'sd77;
      release_coeff <= 16'd65508;
      lookahead_len <= '0;
      gain_reg <= '0;
      peak_reg <= '0;
      dindex <= '0;
      wrapped <= 1'b0;
      cl_dirty <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (mag_in > peak_reg) begin
          peak_reg <= mag_in;
        end
        if (len_eff != '0) begin
          if (idx_inc >= len_eff) begin
            dindex <= '0;
            wrapped <= 1'b1;
          end else begin
            dindex <= idx_inc[LA_AW-1:0];
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_THRESHOLD: threshold_db <= cfg_data;
          REG_CEILING: begin
            ceiling_db <= cfg_data;
            cl_dirty <= 1'b1;
          end
          REG_RELEASE: release_coeff <= cfg_data;
          REG_LOOKAHEAD: begin
            lookahead_len <= cfg_data[LEN_W-1:0];
            dindex <= '0;
            wrapped <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == ST_CL_LIN && !ceiling_db[15]) begin
        cl_dirty <= 1'b0;
      end
      if (state == ST_EXP_END && exp_ceil) begin
        cl_dirty <= 1'b0;
      end
      if (state == ST_TARGET && target < gain_reg) begin
        gain_reg <= target;
      end
      if (state == ST_REL_B) begin
        gain_reg <= (rel_sum[32:16] > 17'd61440) ? GAIN_FLOOR : 17'(17'd0 - rel_sum[32:16]);
      end
      if (state == ST_OUTPUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          smp <= sample;
          mag <= mag_in;
          use_delay <= (len_eff != '0);
          was_wrapped <= wrapped;
        end
      end
      ST_CL_LIN: begin
        if (ceiling_db[15]) begin
          lreg <= 23'((mul_p[38:0] + 39'd32768) >> 16);
          m_work <= 31'(32'd1 << 30);
          step <= 4'd15;
          exp_ceil <= 1'b1;
        end else begin
          cl_level <= SAMPLE_BITS'(32'd1 << (SAMPLE_BITS - 1));
        end
      end
      ST_LOG_NORM: begin
        dly <= use_delay ? (was_wrapped ? ram_rdata : '0) : smp;
        if (mag == '0) begin
          lvl <= SILENCE_DB;
        end else begin
          e_pos <= msb_pos;
          m_work <= 31'(mag) << (5'd30 - msb_pos);
          frac <= '0;
          step <= 4'd15;
        end
      end
      ST_LOG_SQ: begin
        if (sq[31]) begin
          m_work <= sq[31:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          m_work <= sq[30:0];
          frac <= {frac[14:0], 1'b0};
        end
        step <= step - 4'd1;
      end
      ST_LEVEL: begin
        lvl <= 17'sd0 - 17'((mul_p[39:0] + 40'd8388608) >> 24);
      end
      ST_TARGET: begin
        target_mag <= 16'(17'sd0 - target);
      end
      ST_REL_A: begin
        acc <= mul_p[32:0];
      end
      ST_GAIN_LIN: begin
        lreg <= 23'((mul_p[38:0] + 39'd32768) >> 16);
        m_work <= 31'(32'd1 << 30);
        step <= 4'd15;
        exp_ceil <= 1'b0;
      end
      ST_EXP: begin
        if (lreg[step]) begin
          m_work <= 31'((mul_p[61:0] + 62'(64'd1 << 29)) >> 30);
        end
        step <= step - 4'd1;
      end
      ST_EXP_END: begin
        if (exp_ceil) begin
          cl_level <= SAMPLE_BITS'((32'(exp_val) + 32'd64) >> 7);
        end else begin
          glin <= exp_val;
        end
      end
      ST_PRODUCT: begin
        if (prod > 25'(cl_level)) begin
          res_mag <= cl_level;
          res_clip <= 1'b1;
        end else begin
          res_mag <= prod[SAMPLE_BITS-1:0];
          res_clip <= 1'b0;
        end
      end
      ST_OUTPUT: begin
        if (out_free) begin
          out_sample <= dly[SAMPLE_BITS-1] ? SAMPLE_BITS'(-res_mag) : res_mag;
          clipped <= res_clip;
          gain_db <= gain_reg;
          peak_mag <= peak_reg;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/lpl_checker.sv =====
// port-level checker for the lookahead peak limiter and its bind
module lpl_port_checker
  import lpl_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic                          clipped,
  input logic signed [16:0]            gain_db,
  input logic [SAMPLE_BITS-1:0]        peak_mag
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("input transaction dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_sample)
      && $stable(clipped) && $stable(gain_db) && $stable(peak_mag))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (gain_db <= 17'sd0) && (gain_db >= GAIN_FLOOR))
    else $error("gain reduction out of range");

endmodule

bind lookahead_peak_limiter lpl_port_checker u_lpl_checker (.*);
